// ===== design/ptts_pkg.sv =====
// shared types and codes for the periodic task tick scheduler
package ptts_pkg;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_ENABLE  = 3'd1;
  localparam logic [2:0] REQ_DISABLE = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [30:0] TICK_PERIOD_RST = 31'd1000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_FIND,
    S_TICK,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] ident;
    logic [30:0] period;
    logic [31:0] elapsed;
    logic [2:0]  prio;
    logic        en;
  } slot_t;

  typedef struct packed {
    logic        start;
    logic        adv;
    logic        stop;
    logic        ins;
    logic        set_en;
    logic        clr_en;
    logic        tick;
    logic [15:0] id;
    logic [30:0] tick_period;
    slot_t       new_slot;
  } cmd_t;

  typedef struct packed {
    logic  hit;
    logic  fire;
    logic  at_end;
    slot_t slot;
  } stat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [2:0]  prio;
    logic [31:0] elapsed;
  } res_t;

endpackage

// ===== design/periodic_task_tick_scheduler_unit.sv =====
// top level of the periodic task tick scheduler: control and cell chain
//
// Requests enter on the s_axis channel: tuser carries the request type,
// tdata the task id, period, priority and start-enabled flag. Results leave
// on the m_axis channel: tuser carries the status, tdata the task id,
// priority and elapsed time, tlast marks the final result of a request.
// tick_period is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, as the block itself does not enforce it. Each table
// slot is a cell of a chain; a token walks the chain one cell per cycle,
// unless a tick waits on a stalled output, to serve enable, disable, query
// and tick requests. An add passes through S_ADD and S_FLUSH to its result;
// enable, disable and query walk up to the matching slot or the last task;
// a tick walks every task. One request is in work at a time; tready is high
// only while idle. Reset empties the table and restores tick_period to 1000000.
// A stalled receiver holds the output register; a tick waits at a firing while
// the held result cannot leave; a new request is accepted while a result waits.
module periodic_task_tick_scheduler_unit #(
  parameter int unsigned MAX_TASKS       = 8,
  parameter int unsigned PRIORITY_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // task_id, task_period, task_priority, start_enabled
  input  logic [2:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // fired_id, fired_priority, elapsed
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);
  import ptts_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [30:0]      tick_q;
  logic [2:0]       req_q;
  logic [15:0]      id_q;
  logic [30:0]      period_q;
  logic [2:0]       prio_q;
  logic             en_q;
  logic [2:0]       prio_sat;
  res_t             held_q, held_d;
  logic             held_v_q, held_v_d;
  res_t             out_q, push_res;
  logic             out_last_q, push_last;
  logic             out_valid_q;
  logic             push;
  logic             out_free;
  logic             accept;
  logic             step_ok;
  cmd_t             cmd;
  stat_t            stat;

  logic  tok_c   [MAX_TASKS+1];
  logic  after_c [MAX_TASKS+1];
  slot_t slot_c  [MAX_TASKS+1];
  stat_t stat_w  [MAX_TASKS];
  logic [MAX_TASKS-1:0] tok_vec;

  assign tok_c[0]   = 1'b0;
  assign after_c[0] = 1'b0;
  assign slot_c[0]  = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    ptts_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .prev_tok_i   (tok_c[k]),
      .prev_after_i (after_c[k]),
      .prev_slot_i  (slot_c[k]),
      .tok_o        (tok_c[k+1]),
      .after_o      (after_c[k+1]),
      .slot_o       (slot_c[k+1]),
      .stat_o       (stat_w[k])
    );
    assign tok_vec[k] = tok_c[k+1];
  end

  always_comb begin
    stat = '0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      stat = stat | stat_w[k];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_ok       = !stat.fire || !held_v_q || out_free;
  assign prio_sat      = (32'(s_axis_tdata[49:47]) >= PRIORITY_LEVELS) ?
                         3'(PRIORITY_LEVELS - 1) : s_axis_tdata[49:47];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            REQ_ADD: state_d = S_ADD;
            REQ_ENABLE, REQ_DISABLE, REQ_QUERY:
              state_d = (count_q == '0) ? S_FLUSH : S_FIND;
            REQ_TICK: state_d = (count_q == '0) ? S_FLUSH : S_TICK;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: state_d = S_FLUSH;
      S_FIND: begin
        if (stat.hit || stat.at_end) begin
          state_d = S_FLUSH;
        end
      end
      S_TICK: begin
        if (step_ok && stat.at_end) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd                  = '0;
    cmd.id               = id_q;
    cmd.tick_period      = tick_q;
    cmd.new_slot.ident   = id_q;
    cmd.new_slot.period  = period_q;
    cmd.new_slot.elapsed = 32'd0;
    cmd.new_slot.prio    = prio_q;
    cmd.new_slot.en      = en_q;
    count_d   = count_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    push      = 1'b0;
    push_res  = held_q;
    push_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            REQ_ENABLE, REQ_DISABLE, REQ_QUERY: begin
              held_d   = '{status: ST_NOTFOUND, id: s_axis_tdata[15:0],
                           prio: 3'd0, elapsed: 32'd0};
              held_v_d = (count_q == '0);
              cmd.start = (count_q != '0);
            end
            REQ_TICK: begin
              held_v_d  = 1'b0;
              cmd.start = (count_q != '0);
            end
            default: begin
              held_v_d = 1'b0;
            end
          endcase
        end
      end
      S_ADD: begin
        held_v_d = 1'b1;
        if (count_q >= CNT_W'(MAX_TASKS)) begin
          held_d = '{status: ST_FULL, id: id_q, prio: 3'd0, elapsed: 32'd0};
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + 1'b1;
          held_d  = '{status: ST_OK, id: id_q, prio: 3'd0, elapsed: 32'd0};
        end
      end
      S_FIND: begin
        if (stat.hit) begin
          cmd.stop   = 1'b1;
          cmd.set_en = (req_q == REQ_ENABLE);
          cmd.clr_en = (req_q == REQ_DISABLE);
          held_v_d   = 1'b1;
          held_d     = '{status: ST_OK, id: id_q, prio: 3'd0,
                         elapsed: (req_q == REQ_QUERY) ? stat.slot.elapsed : 32'd0};
        end else if (stat.at_end) begin
          cmd.stop = 1'b1;
          held_v_d = 1'b1;
          held_d   = '{status: ST_NOTFOUND, id: id_q, prio: 3'd0, elapsed: 32'd0};
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_TICK: begin
        if (step_ok) begin
          cmd.tick = 1'b1;
          cmd.stop = stat.at_end;
          cmd.adv  = !stat.at_end;
          if (stat.fire) begin
            push     = held_v_q;
            push_res = held_q;
            held_v_d = 1'b1;
            held_d   = '{status: ST_OK, id: stat.slot.ident,
                         prio: stat.slot.prio, elapsed: 32'd0};
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_res  = held_v_q ? held_q :
                      res_t'{status: ST_NONE, id: 16'd0, prio: 3'd0, elapsed: 32'd0};
          held_v_d  = 1'b0;
        end
      end
      default: begin
        held_v_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tick_q      <= TICK_PERIOD_RST;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      held_v_q <= held_v_d;
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (accept) begin
      req_q    <= s_axis_tuser;
      id_q     <= s_axis_tdata[15:0];
      period_q <= s_axis_tdata[46:16];
      prio_q   <= prio_sat;
      en_q     <= s_axis_tdata[50];
    end
    if (push) begin
      out_q      <= push_res;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.elapsed, out_q.prio, out_q.id};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  a_tok_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one visit token");

  a_tok_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND || state_q == S_TICK) |-> $onehot(tok_vec))
    else $error("walk without a token");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("output register overwritten");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!held_v_q && tok_vec == '0))
    else $error("idle with pending result or token");

endmodule

// ===== design/ptts_cell.sv =====
// one task slot of the scheduler chain with its visit token
module ptts_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptts_pkg::cmd_t    cmd_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              prev_tok_i,
  input  logic              prev_after_i,
  input  ptts_pkg::slot_t   prev_slot_i,
  output logic              tok_o,
  output logic              after_o,
  output ptts_pkg::slot_t   slot_o,
  output ptts_pkg::stat_t   stat_o
);
  import ptts_pkg::*;

  slot_t       slot_q, slot_d;
  logic        tok_q, tok_d;
  logic        after;
  logic        fire;
  logic [31:0] base;
  logic [32:0] sum;

  assign after = (CNT_W'(IDX) >= count_i) || (slot_q.prio > cmd_i.new_slot.prio);
  assign fire  = slot_q.en && (slot_q.elapsed >= {1'b0, slot_q.period});
  assign base  = fire ? 32'd0 : slot_q.elapsed;
  assign sum   = {1'b0, base} + {2'b00, cmd_i.tick_period};

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.ins) begin
      if (prev_after_i) begin
        slot_d = prev_slot_i;
      end else if (after) begin
        slot_d = cmd_i.new_slot;
      end
    end else if (tok_q) begin
      if (cmd_i.set_en) begin
        slot_d.en = 1'b1;
      end else if (cmd_i.clr_en) begin
        slot_d.en = 1'b0;
      end else if (cmd_i.tick && slot_q.en) begin
        slot_d.elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
  end

  always_comb begin
    tok_d = tok_q;
    if (cmd_i.start) begin
      tok_d = (IDX == 0);
    end else if (cmd_i.stop) begin
      tok_d = 1'b0;
    end else if (cmd_i.adv) begin
      tok_d = prev_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign tok_o   = tok_q;
  assign after_o = after;
  assign slot_o  = slot_q;

  always_comb begin
    stat_o        = '0;
    stat_o.hit    = tok_q && (slot_q.ident == cmd_i.id);
    stat_o.fire   = tok_q && fire;
    stat_o.at_end = tok_q && (count_i == CNT_W'(IDX + 1));
    stat_o.slot   = tok_q ? slot_q : '0;
  end

endmodule
